[rtl/dlt_pkg.sv]
// Shared types, codes and widths for the dedup list table.
`default_nettype none
package dlt_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned WIDE_W   = 9;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_CONTAINS = 2'd2,
    REQ_GET      = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_NULL  = 3'd1,
    ST_MISS  = 3'd2,
    ST_FULL  = 3'd3,
    ST_RANGE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    RK_NULL,
    RK_RANGE,
    RK_GET,
    RK_MISS,
    RK_FULL,
    RK_APPEND,
    RK_FOUND,
    RK_REMOVED
  } res_kind_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DECODE,
    FSM_GET,
    FSM_SCAN,
    FSM_SHIFT,
    FSM_FINISH
  } state_e;

  typedef struct packed {
    logic      load;
    logic      scan;
    logic      shift_start;
    logic      shift;
    logic      get_read;
    logic      resolve;
    res_kind_e kind;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic val_zero;
    logic in_range;
    logic full;
    logic more;
    logic hit;
    logic rd_vld;
  } stat_t;

endpackage
`default_nettype wire

[rtl/dlt_if.sv]
// Request and response channel interfaces of the dedup list table.
`default_nettype none
interface dlt_req_if;
  import dlt_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [VALUE_W-1:0] item_value;
  logic [INDEX_W-1:0] item_index;

  modport source (output valid, req_type, item_value, item_index, input ready);
  modport sink   (input valid, req_type, item_value, item_index, output ready);
endinterface

interface dlt_rsp_if;
  import dlt_pkg::*;

  logic                valid;
  logic                ready;
  logic                success;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  read_value;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, success, status, read_value, entry_count, input ready);
  modport sink   (input valid, success, status, read_value, entry_count, output ready);
endinterface
`default_nettype wire

[rtl/dlt_dp.sv]
// Datapath: entry memory, count, scan pointer, compare and result registers.
`default_nettype none
module dlt_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire dlt_pkg::cmd_t                cmd_i,
  output dlt_pkg::stat_t                    stat_o,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic [dlt_pkg::VALUE_W-1:0]  item_value_i,
  input  wire logic [dlt_pkg::INDEX_W-1:0]  item_index_i,
  output logic                              success_o,
  output logic [dlt_pkg::STATUS_W-1:0]      status_o,
  output logic [dlt_pkg::VALUE_W-1:0]       read_value_o,
  output logic [dlt_pkg::COUNT_W-1:0]       entry_count_o
);
  import dlt_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [VALUE_W-1:0] mem [CAPACITY];

  req_e               req_q;
  logic [VALUE_W-1:0] val_q;
  logic [INDEX_W-1:0] idx_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic               rd_vld_q, rd_vld_d;
  logic [AW-1:0]      rd_idx_q;
  logic [VALUE_W-1:0] rdata_q;

  logic               res_ok_q;
  status_e            res_st_q;
  logic [VALUE_W-1:0] res_rd_q;

  logic [WIDE_W-1:0]  idx_wide, count_wide;
  logic               more;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [VALUE_W-1:0] wr_data;

  assign idx_wide   = WIDE_W'(idx_q);
  assign count_wide = WIDE_W'(count_q);
  assign more       = ptr_q < count_q;

  assign stat_o.req      = req_q;
  assign stat_o.val_zero = val_q == '0;
  assign stat_o.in_range = idx_wide < count_wide;
  assign stat_o.full     = count_q == CW'(CAPACITY);
  assign stat_o.more     = more;
  assign stat_o.hit      = rd_vld_q && (rdata_q == val_q);
  assign stat_o.rd_vld   = rd_vld_q;

  assign rd_en   = cmd_i.get_read || ((cmd_i.scan || cmd_i.shift) && more);
  assign rd_addr = cmd_i.get_read ? idx_wide[AW-1:0] : ptr_q[AW-1:0];
  assign wr_en   = (cmd_i.shift && rd_vld_q) || (cmd_i.resolve && cmd_i.kind == RK_APPEND);
  assign wr_addr = cmd_i.shift ? rd_idx_q - AW'(1) : count_q[AW-1:0];
  assign wr_data = cmd_i.shift ? rdata_q : val_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q  <= mem[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  always_comb begin
    count_d  = count_q;
    ptr_d    = ptr_q;
    rd_vld_d = rd_vld_q;
    if (cmd_i.load) begin
      ptr_d    = '0;
      rd_vld_d = 1'b0;
    end
    if (cmd_i.scan || cmd_i.shift) begin
      ptr_d    = more ? ptr_q + CW'(1) : ptr_q;
      rd_vld_d = more;
    end
    if (cmd_i.shift_start) begin
      ptr_d    = CW'(rd_idx_q) + CW'(1);
      rd_vld_d = 1'b0;
    end
    if (cmd_i.resolve && cmd_i.kind == RK_APPEND) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.resolve && cmd_i.kind == RK_REMOVED) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_e'(req_type_i);
      val_q <= item_value_i;
      idx_q <= item_index_i;
    end
    if (cmd_i.resolve) begin
      res_rd_q <= '0;
      unique case (cmd_i.kind)
        RK_NULL: begin
          res_ok_q <= 1'b0;
          res_st_q <= ST_NULL;
        end
        RK_RANGE: begin
          res_ok_q <= 1'b0;
          res_st_q <= ST_RANGE;
        end
        RK_GET: begin
          res_ok_q <= 1'b1;
          res_st_q <= ST_OK;
          res_rd_q <= rdata_q;
        end
        RK_MISS: begin
          res_ok_q <= 1'b0;
          res_st_q <= ST_MISS;
        end
        RK_FULL: begin
          res_ok_q <= 1'b0;
          res_st_q <= ST_FULL;
        end
        default: begin
          res_ok_q <= 1'b1;
          res_st_q <= ST_OK;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      success_o     <= res_ok_q;
      status_o      <= res_st_q;
      read_value_o  <= res_rd_q;
      entry_count_o <= count_wide[COUNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

[rtl/dlt_ctrl.sv]
// Controller: request sequencing state machine and output valid flag.
`default_nettype none
module dlt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire dlt_pkg::stat_t stat_i,
  output dlt_pkg::cmd_t       cmd_o
);
  import dlt_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = FSM_DECODE;
        end
      end
      FSM_DECODE: begin
        if (stat_i.req == REQ_GET) begin
          if (stat_i.in_range) begin
            cmd_o.get_read = 1'b1;
            state_d        = FSM_GET;
          end else begin
            cmd_o.resolve = 1'b1;
            cmd_o.kind    = RK_RANGE;
            state_d       = FSM_FINISH;
          end
        end else if (stat_i.val_zero) begin
          cmd_o.resolve = 1'b1;
          cmd_o.kind    = RK_NULL;
          state_d       = FSM_FINISH;
        end else begin
          state_d = FSM_SCAN;
        end
      end
      FSM_GET: begin
        cmd_o.resolve = 1'b1;
        cmd_o.kind    = RK_GET;
        state_d       = FSM_FINISH;
      end
      FSM_SCAN: begin
        if (stat_i.hit) begin
          case (stat_i.req)
            REQ_REMOVE: begin
              cmd_o.shift_start = 1'b1;
              state_d           = FSM_SHIFT;
            end
            REQ_CONTAINS: begin
              cmd_o.resolve = 1'b1;
              cmd_o.kind    = RK_FOUND;
              state_d       = FSM_FINISH;
            end
            default: begin
              cmd_o.resolve = 1'b1;
              cmd_o.kind    = RK_MISS;
              state_d       = FSM_FINISH;
            end
          endcase
        end else if (!stat_i.rd_vld && !stat_i.more) begin
          cmd_o.resolve = 1'b1;
          state_d       = FSM_FINISH;
          if (stat_i.req == REQ_ADD) begin
            cmd_o.kind = stat_i.full ? RK_FULL : RK_APPEND;
          end else begin
            cmd_o.kind = RK_MISS;
          end
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      FSM_SHIFT: begin
        if (!stat_i.rd_vld && !stat_i.more) begin
          cmd_o.resolve = 1'b1;
          cmd_o.kind    = RK_REMOVED;
          state_d       = FSM_FINISH;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      FSM_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/dedup_list_table_core.sv]
// Get and null requests resolve without a scan; add and contains run a linear scan; remove
// scans, then shifts through the one-read, one-write entry memory. One request in flight;
// the next is accepted once the previous result sits in the output register.
// Reset clears the count and the control state; entry storage is not cleared and needs no
// clearing pass, as only entries below the count are ever read.
`default_nettype none
module dedup_list_table_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dlt_req_if.sink   req_i,
  dlt_rsp_if.source rsp_o
);
  import dlt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dlt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_type_i    (req_i.req_type),
    .item_value_i  (req_i.item_value),
    .item_index_i  (req_i.item_index),
    .success_o     (rsp_o.success),
    .status_o      (rsp_o.status),
    .read_value_o  (rsp_o.read_value),
    .entry_count_o (rsp_o.entry_count)
  );

endmodule
`default_nettype wire

[sim/dlt_reply_checker.sv]
// Scoreboard for the dedup list table: predicts each reply from the requests and checks it.
`default_nettype none
module dlt_reply_checker
  import dlt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dlt_req_if        req_mon,
  dlt_rsp_if        rsp_mon,
  output int        mismatches_o,
  output int        replies_due_o
);

  typedef struct packed {
    logic               success;
    status_e            status;
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] entry_count;
  } reply_t;

  logic [VALUE_W-1:0] table_q [CAPACITY];
  int                 fill_q;
  int                 mismatches;
  reply_t             replies_due[$];

  // Updates the shadow table and returns the reply the block owes for this item.
  function automatic reply_t apply_request(input req_e op, input logic [VALUE_W-1:0] value,
                                           input logic [INDEX_W-1:0] index);
    reply_t r;
    int     pos;
    r.success    = 1'b0;
    r.status     = ST_OK;
    r.read_value = '0;
    pos          = -1;
    if (op == REQ_GET) begin
      if (int'(index) < fill_q) begin
        r.success    = 1'b1;
        r.read_value = table_q[index];
      end else begin
        r.status = ST_RANGE;
      end
    end else if (value == '0) begin
      r.status = ST_NULL;
    end else begin
      for (int i = 0; i < fill_q; i++) begin
        if (pos < 0 && table_q[i] == value) pos = i;
      end
      case (op)
        REQ_ADD: begin
          if (pos >= 0) begin
            r.status = ST_MISS;
          end else if (fill_q >= int'(CAPACITY)) begin
            r.status = ST_FULL;
          end else begin
            table_q[fill_q] = value;
            fill_q++;
            r.success = 1'b1;
          end
        end
        REQ_REMOVE: begin
          if (pos < 0) begin
            r.status = ST_MISS;
          end else begin
            for (int j = pos; j + 1 < fill_q; j++) table_q[j] = table_q[j+1];
            fill_q--;
            r.success = 1'b1;
          end
        end
        default: begin
          if (pos >= 0) r.success = 1'b1;
          else r.status = ST_MISS;
        end
      endcase
    end
    r.entry_count = COUNT_W'(fill_q);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t seen;
    reply_t want;
    if (!rst_ni) begin
      fill_q     = 0;
      mismatches = 0;
      replies_due.delete();
      mismatches_o  <= 0;
      replies_due_o <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        seen.success     = rsp_mon.success;
        seen.status      = status_e'(rsp_mon.status);
        seen.read_value  = rsp_mon.read_value;
        seen.entry_count = rsp_mon.entry_count;
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply: expected none, got success %0b status %0d",
                   $time, seen.success, seen.status);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (seen.success !== want.success) begin
            $display("%0t: success mismatch: expected %0b, got %0b",
                     $time, want.success, seen.success);
            mismatches++;
          end
          if (seen.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, seen.status);
            mismatches++;
          end
          if (seen.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch: expected %h, got %h",
                     $time, want.read_value, seen.read_value);
            mismatches++;
          end
          if (seen.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch: expected %0d, got %0d",
                     $time, want.entry_count, seen.entry_count);
            mismatches++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        replies_due.push_back(apply_request(req_e'(req_mon.req_type), req_mon.item_value,
                                            req_mon.item_index));
      end
      mismatches_o  <= mismatches;
      replies_due_o <= replies_due.size();
    end
  end

endmodule
`default_nettype wire

[sim/tb_dedup_list_table_core.sv]
// Testbench top for the dedup list table: clock, reset, request stimulus and verdict.
`default_nettype none
module tb_dedup_list_table_core;
  import dlt_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int          POOL_SIZE    = 24;
  localparam int          RANDOM_ITEMS = 450;
  localparam int          STALL_LIMIT  = 4000;

  logic               clk_i;
  logic               rst_ni;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 items_sent;
  int                 stall_cycles;
  int                 mismatches;
  int                 replies_due;
  logic [VALUE_W-1:0] value_pool [POOL_SIZE];

  dlt_req_if req_if();
  dlt_rsp_if rsp_if();

  dedup_list_table_core #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  dlt_reply_checker #(
    .CAPACITY(TABLE_DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .mismatches_o (mismatches),
    .replies_due_o(replies_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
    end
  end

  initial stall_cycles = 0;

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_req(input req_e op, input logic [VALUE_W-1:0] value,
                          input logic [INDEX_W-1:0] index);
    req_if.valid      <= 1'b1;
    req_if.req_type   <= op;
    req_if.item_value <= value;
    req_if.item_index <= index;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    items_sent++;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Holds the request side off until every outstanding reply is back.
  task automatic drain_replies();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (replies_due != 0);
  endtask

  initial begin
    int                 pick;
    int                 base;
    int                 phase_end;
    logic [VALUE_W-1:0] value;
    items_sent        = 0;
    send_idle_pct     = 7;
    recv_idle_pct     = 75;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_ADD;
    req_if.item_value <= '0;
    req_if.item_index <= '0;
    for (int k = 0; k < POOL_SIZE; k++) value_pool[k] = $urandom_range(32'hFFFF_FFFF, 1);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, null values, duplicates, first and last removal
    send_req(REQ_GET, 32'h1, 4'd0);
    send_req(REQ_ADD, 32'h0, 4'd0);
    send_req(REQ_REMOVE, 32'h0, 4'd0);
    send_req(REQ_CONTAINS, 32'h0, 4'd0);
    send_req(REQ_REMOVE, 32'hFFFF_FFFF, 4'd0);
    send_req(REQ_CONTAINS, 32'h1, 4'd0);
    send_req(REQ_ADD, 32'hFFFF_FFFF, 4'd15);
    send_req(REQ_ADD, 32'h1, 4'd0);
    send_req(REQ_ADD, 32'h1, 4'd0);
    send_req(REQ_ADD, 32'h8000_0000, 4'd0);
    send_req(REQ_CONTAINS, 32'hFFFF_FFFF, 4'd0);
    send_req(REQ_GET, 32'h0, 4'd0);
    send_req(REQ_GET, 32'hFFFF_FFFF, 4'd2);
    send_req(REQ_GET, 32'h0, 4'd3);
    send_req(REQ_GET, 32'h0, 4'd15);
    send_req(REQ_REMOVE, 32'hFFFF_FFFF, 4'd0);
    send_req(REQ_GET, 32'h0, 4'd0);
    send_req(REQ_REMOVE, 32'h8000_0000, 4'd0);
    send_req(REQ_CONTAINS, 32'h8000_0000, 4'd0);
    send_req(REQ_GET, 32'h0, 4'd0);
    send_req(REQ_REMOVE, 32'h1, 4'd0);
    send_req(REQ_GET, 32'h0, 4'd0);
    drain_replies();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_end = items_sent + RANDOM_ITEMS / 3;
      pick      = 0;
      while (items_sent < phase_end) begin
        base = $urandom_range(POOL_SIZE - 1);
        if (pick < 2) begin
          // fill past capacity, then read every slot of the full table
          for (int k = 0; k < 20; k++)
            send_req(REQ_ADD, value_pool[(base + k) % POOL_SIZE], 4'($urandom_range(15)));
          send_req(REQ_ADD, $urandom_range(32'hFFFF_FFFF, 1), 4'($urandom_range(15)));
          for (int k = 0; k < int'(TABLE_DEPTH); k++) send_req(REQ_GET, $urandom, 4'(k));
        end else if (pick < 4) begin
          for (int k = 0; k < POOL_SIZE; k++)
            send_req(REQ_REMOVE, value_pool[(base + k) % POOL_SIZE], 4'($urandom_range(15)));
          send_req(REQ_CONTAINS, value_pool[base], 4'($urandom_range(15)));
        end else begin
          for (int k = 0; k < 24; k++) begin
            pick = $urandom_range(99);
            if (pick < 8) value = '0;
            else if (pick < 70) value = value_pool[$urandom_range(POOL_SIZE - 1)];
            else value = $urandom;
            send_req(req_e'($urandom_range(3)), value, 4'($urandom_range(15)));
          end
        end
        pick = $urandom_range(9);
      end
      drain_replies();
    end

    drain_replies();
    repeat (2 * TABLE_DEPTH) @(posedge clk_i);
    if (mismatches == 0 && replies_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
